/* rtl/laplace_5pt_stencil_stream_macros.svh */
// assertion macros shared by the laplacian stencil rtl
// expects i_clk and i_rst_n in the scope of use
`ifndef LAPLACE_5PT_STENCIL_STREAM_MACROS_SVH
`define LAPLACE_5PT_STENCIL_STREAM_MACROS_SVH

// same-cycle implication, checked outside reset
`define LSP_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define LSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/lsp_pkg.sv */
// shared types and constants for the laplacian stencil block
// no dependencies
`default_nettype none

package lsp_pkg;

    localparam int ROWS_W         = 16;
    localparam int COLS_W         = 11;
    localparam int COLS_FIELD_MAX = 2047;
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;
    localparam int REG_SEL_BIT    = 2;

    localparam logic [ROWS_W-1:0] ROWS_RESET = 16'd8;
    localparam logic [COLS_W-1:0] COLS_RESET = 11'd7;

    typedef enum logic {
        REG_GRID_ROWS = 1'b0,
        REG_GRID_COLS = 1'b1
    } t_reg_idx;

    typedef enum logic {
        FUNC_SAMPLE = 1'b0,
        FUNC_DRAIN  = 1'b1
    } t_func;

    typedef struct packed {
        logic [ROWS_W-1:0] grid_rows;
        logic [COLS_W-1:0] grid_cols;
        logic              restart;
    } t_cfg;

    typedef struct packed {
        logic shift;
        logic load_entry;
    } t_cell_ctrl;

endpackage

`default_nettype wire

/* rtl/lsp_stream_if.sv */
// valid/ready channels for sample beats and result beats
// no dependencies
`default_nettype none

interface lsp_sample_if #(
    parameter int SAMPLE_BITS = 32
);
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic signed [SAMPLE_BITS-1:0] sample_value;

    modport source (output valid, output func, output sample_value, input ready);
    modport sink   (input valid, input func, input sample_value, output ready);
endinterface

interface lsp_result_if #(
    parameter int SAMPLE_BITS = 32
);
    logic                            valid;
    logic                            ready;
    logic signed [SAMPLE_BITS+2:0]   stencil_value;
    logic                            last_point;

    modport source (output valid, output stencil_value, output last_point, input ready);
    modport sink   (input valid, input stencil_value, input last_point, output ready);
endinterface

`default_nettype wire

/* rtl/lsp_cell.sv */
// one column slot of the two line stores: centre and upper samples
// depends on lsp_pkg
`default_nettype none

module lsp_cell #(
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                          i_clk,
    input  wire lsp_pkg::t_cell_ctrl           i_ctrl,
    input  wire logic signed [SAMPLE_BITS-1:0] i_next_centre,
    input  wire logic signed [SAMPLE_BITS-1:0] i_next_upper,
    input  wire logic signed [SAMPLE_BITS-1:0] i_entry_centre,
    input  wire logic signed [SAMPLE_BITS-1:0] i_entry_upper,
    output logic signed [SAMPLE_BITS-1:0]      o_centre,
    output logic signed [SAMPLE_BITS-1:0]      o_upper
);

    logic signed [SAMPLE_BITS-1:0] r_centre;
    logic signed [SAMPLE_BITS-1:0] r_upper;

    // entry slot takes the new beat, the others take their neighbour
    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            if (i_ctrl.load_entry) begin
                r_centre <= i_entry_centre;
                r_upper  <= i_entry_upper;
            end else begin
                r_centre <= i_next_centre;
                r_upper  <= i_next_upper;
            end
        end
    end

    assign o_centre = r_centre;
    assign o_upper  = r_upper;

endmodule

`default_nettype wire

/* rtl/lsp_chain.sv */
// chain of column cells forming both line stores as a variable-length shift line
// depends on lsp_pkg and lsp_cell
`default_nettype none

module lsp_chain #(
    parameter int CELLS       = 1024,
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_shift,
    input  wire logic [$clog2(CELLS)-1:0]      i_entry_idx,
    input  wire logic signed [SAMPLE_BITS-1:0] i_entry_centre,
    input  wire logic signed [SAMPLE_BITS-1:0] i_entry_upper,
    output logic signed [SAMPLE_BITS-1:0]      o_mid,
    output logic signed [SAMPLE_BITS-1:0]      o_up,
    output logic signed [SAMPLE_BITS-1:0]      o_right
);

    localparam int IDX_W = $clog2(CELLS);

    logic signed [SAMPLE_BITS-1:0] w_centre [CELLS];
    logic signed [SAMPLE_BITS-1:0] w_upper  [CELLS];
    lsp_pkg::t_cell_ctrl           w_ctrl   [CELLS];

    for (genvar k = 0; k < CELLS; k++) begin : g_cell
        assign w_ctrl[k] = '{shift: i_shift, load_entry: (i_entry_idx == IDX_W'(k))};

        if (k == CELLS - 1) begin : g_tail
            // tail slot only ever loads from the entry
            lsp_cell #(
                .SAMPLE_BITS (SAMPLE_BITS)
            ) u_cell (
                .i_clk          (i_clk),
                .i_ctrl         (w_ctrl[k]),
                .i_next_centre  (i_entry_centre),
                .i_next_upper   (i_entry_upper),
                .i_entry_centre (i_entry_centre),
                .i_entry_upper  (i_entry_upper),
                .o_centre       (w_centre[k]),
                .o_upper        (w_upper[k])
            );
        end else begin : g_body
            lsp_cell #(
                .SAMPLE_BITS (SAMPLE_BITS)
            ) u_cell (
                .i_clk          (i_clk),
                .i_ctrl         (w_ctrl[k]),
                .i_next_centre  (w_centre[k+1]),
                .i_next_upper   (w_upper[k+1]),
                .i_entry_centre (i_entry_centre),
                .i_entry_upper  (i_entry_upper),
                .o_centre       (w_centre[k]),
                .o_upper        (w_upper[k])
            );
        end
    end

    // head of the line is the current column, next slot the column to its right
    assign o_mid   = w_centre[0];
    assign o_up    = w_upper[0];
    assign o_right = w_centre[1];

endmodule

`default_nettype wire

/* rtl/lsp_apb_regs.sv */
// apb register file: grid_rows and grid_cols, write strobe restarts the stream
// depends on lsp_pkg
`default_nettype none

module lsp_apb_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lsp_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [lsp_pkg::PDATA_W-1:0]   pwdata,
    output logic [lsp_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready,
    output lsp_pkg::t_cfg                      o_cfg
);

    logic [lsp_pkg::ROWS_W-1:0] r_grid_rows;
    logic [lsp_pkg::COLS_W-1:0] r_grid_cols;
    logic                       w_wr;
    lsp_pkg::t_reg_idx          w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = lsp_pkg::t_reg_idx'(paddr[lsp_pkg::REG_SEL_BIT]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= lsp_pkg::ROWS_RESET;
            r_grid_cols <= lsp_pkg::COLS_RESET;
        end else if (w_wr) begin
            case (w_idx)
                lsp_pkg::REG_GRID_ROWS: begin
                    r_grid_rows <= pwdata[lsp_pkg::ROWS_W-1:0];
                end
                lsp_pkg::REG_GRID_COLS: begin
                    r_grid_cols <= pwdata[lsp_pkg::COLS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            lsp_pkg::REG_GRID_ROWS: prdata = lsp_pkg::PDATA_W'(r_grid_rows);
            lsp_pkg::REG_GRID_COLS: prdata = lsp_pkg::PDATA_W'(r_grid_cols);
            default:                prdata = '0;
        endcase
    end

    assign o_cfg = '{grid_rows: r_grid_rows, grid_cols: r_grid_cols, restart: w_wr};

endmodule

`default_nettype wire

/* rtl/laplace_5pt_stencil_stream.sv */
// five-point laplacian over a raster grid stream; uses lsp_pkg, lsp_stream_if,
// lsp_chain, lsp_apb_regs and the assertion macros header
// throughput: one beat per cycle on the sample side while the result side does not stall, results back to back
// result for (i,j) enters the two-stage adder pipeline with the beat carrying (i+1,j)
//   (or the drain tick for the last row): operand stage first, then the output register
// reset: synchronous, active low; clears position, drain flag and pipe valids,
//   line cells are not cleared (always rewritten before use), no clearing pass
`default_nettype none
`include "laplace_5pt_stencil_stream_macros.svh"

module laplace_5pt_stencil_stream #(
    parameter int MAX_COLS    = 1024,
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    lsp_sample_if.sink                       i_sample_ch,
    lsp_result_if.source                     o_result_ch,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [lsp_pkg::PADDR_W-1:0] paddr,
    input  wire logic [lsp_pkg::PDATA_W-1:0] pwdata,
    output logic [lsp_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready
);

    // grid_cols can never exceed its field, so the chain stops there
    localparam int COLS_W = lsp_pkg::COLS_W;
    localparam int ROWS_W = lsp_pkg::ROWS_W;
    localparam int CHAIN  = (MAX_COLS < lsp_pkg::COLS_FIELD_MAX) ? MAX_COLS
                                                                 : lsp_pkg::COLS_FIELD_MAX;
    localparam int COL_W  = $clog2(CHAIN);
    localparam int CNT_W  = $clog2(CHAIN + 1);
    localparam int RES_W  = SAMPLE_BITS + 3;
    localparam int PAIR_W = SAMPLE_BITS + 1;

    // configuration
    lsp_pkg::t_cfg     w_cfg;
    logic [CNT_W-1:0]  w_cols_eff;
    logic [COL_W-1:0]  w_last_col;
    logic [ROWS_W-1:0] w_rows_eff;

    // raster position and drain
    logic [ROWS_W-1:0] r_row;
    logic [ROWS_W-1:0] n_row;
    logic [COL_W-1:0]  r_col;
    logic [COL_W-1:0]  n_col;
    logic              r_draining;
    logic              n_draining;
    logic              w_col_last;
    logic              w_row_last;

    // beat handling
    logic w_out_free;
    logic w_s1_free;
    logic w_in_fire;
    logic w_is_drain;
    logic w_take_sample;
    logic w_take_drain;
    logic w_shift;
    logic w_produce;
    logic w_has_up;

    // stencil operands
    logic signed [SAMPLE_BITS-1:0] w_chain_mid;
    logic signed [SAMPLE_BITS-1:0] w_chain_up;
    logic signed [SAMPLE_BITS-1:0] w_chain_right;
    logic signed [SAMPLE_BITS-1:0] w_down;
    logic signed [SAMPLE_BITS-1:0] w_up;
    logic signed [SAMPLE_BITS-1:0] w_left;
    logic signed [SAMPLE_BITS-1:0] w_right;
    logic signed [SAMPLE_BITS-1:0] r_left;

    // adder pipeline
    logic                          r_s1_valid;
    logic signed [RES_W-1:0]       r_s1_a;
    logic signed [RES_W-1:0]       n_s1_a;
    logic signed [PAIR_W-1:0]      r_s1_b;
    logic signed [PAIR_W-1:0]      n_s1_b;
    logic signed [SAMPLE_BITS-1:0] r_s1_right;
    logic                          r_s1_last;
    logic                          r_o_valid;
    logic signed [RES_W-1:0]       r_o_value;
    logic signed [RES_W-1:0]       n_o_value;
    logic                          r_o_last;

    lsp_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // zero rows or columns act as one, columns clamp to the chain length
    always_comb begin
        if (w_cfg.grid_cols == '0) begin
            w_cols_eff = CNT_W'(1);
        end else if (w_cfg.grid_cols > COLS_W'(CHAIN)) begin
            w_cols_eff = CNT_W'(CHAIN);
        end else begin
            w_cols_eff = CNT_W'(w_cfg.grid_cols);
        end
    end

    assign w_last_col = COL_W'(w_cols_eff - CNT_W'(1));
    assign w_rows_eff = (w_cfg.grid_rows == '0) ? ROWS_W'(1) : w_cfg.grid_rows;
    assign w_col_last = (r_col == w_last_col);
    assign w_row_last = (r_row == w_rows_eff - ROWS_W'(1));

    // handshake: output register plus one operand stage, ready follows the stage valids and result ready
    assign w_out_free = !r_o_valid || o_result_ch.ready;
    assign w_s1_free  = !r_s1_valid || w_out_free;
    assign w_in_fire  = i_sample_ch.valid && w_s1_free;
    assign i_sample_ch.ready = w_s1_free;

    // samples during drain and drain ticks outside it are taken and dropped
    assign w_is_drain    = (i_sample_ch.func == lsp_pkg::FUNC_DRAIN);
    assign w_take_sample = w_in_fire && !w_is_drain && !r_draining;
    assign w_take_drain  = w_in_fire && w_is_drain && r_draining;
    assign w_shift       = w_take_sample || w_take_drain;
    assign w_produce     = (w_take_sample && (r_row != '0)) || w_take_drain;

    // upper neighbour exists from the third row on; during drain only if rows >= 2
    assign w_has_up = w_is_drain ? (w_rows_eff[ROWS_W-1:1] != '0)
                                 : (r_row[ROWS_W-1:1] != '0);

    // drain ticks push zeros in as the row below
    assign w_down  = w_is_drain ? '0 : i_sample_ch.sample_value;
    assign w_up    = w_has_up ? w_chain_up : '0;
    assign w_left  = (r_col == '0) ? '0 : r_left;
    assign w_right = w_col_last ? '0 : w_chain_right;

    // line stores: head cell holds the centre row at this column, entry takes
    // the new sample as centre and the outgoing centre as upper
    lsp_chain #(
        .CELLS       (CHAIN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_chain (
        .i_clk          (i_clk),
        .i_shift        (w_shift),
        .i_entry_idx    (w_last_col),
        .i_entry_centre (w_down),
        .i_entry_upper  (w_chain_mid),
        .o_mid          (w_chain_mid),
        .o_up           (w_chain_up),
        .o_right        (w_chain_right)
    );

    // raster walk; a register write restarts the grid
    always_comb begin
        n_row      = r_row;
        n_col      = r_col;
        n_draining = r_draining;
        if (w_cfg.restart) begin
            n_row      = '0;
            n_col      = '0;
            n_draining = 1'b0;
        end else if (w_take_sample) begin
            if (w_col_last) begin
                n_col = '0;
                if (w_row_last) begin
                    n_row      = '0;
                    n_draining = 1'b1;
                end else begin
                    n_row = r_row + ROWS_W'(1);
                end
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end else if (w_take_drain) begin
            if (w_col_last) begin
                n_col      = '0;
                n_draining = 1'b0;
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    // first stage forms two partial sums of the five-term sum and carries the right neighbour
    assign n_s1_a    = (RES_W'(w_chain_mid) <<< 2) - RES_W'(w_up);
    assign n_s1_b    = PAIR_W'(w_down) + PAIR_W'(w_left);
    assign n_o_value = r_s1_a - (RES_W'(r_s1_b) + RES_W'(r_s1_right));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_col      <= '0;
            r_draining <= 1'b0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_row      <= n_row;
            r_col      <= n_col;
            r_draining <= n_draining;
            if (w_s1_free) begin
                r_s1_valid <= w_produce;
            end
            if (w_out_free) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_left <= w_chain_mid;
        end
        if (w_produce) begin
            r_s1_a     <= n_s1_a;
            r_s1_b     <= n_s1_b;
            r_s1_right <= w_right;
            r_s1_last  <= w_take_drain && w_col_last;
        end
        if (w_out_free && r_s1_valid) begin
            r_o_value <= n_o_value;
            r_o_last  <= r_s1_last;
        end
    end

    assign o_result_ch.valid         = r_o_valid;
    assign o_result_ch.stencil_value = r_o_value;
    assign o_result_ch.last_point    = r_o_last;

    `LSP_ASSERT_IMPLY(a_drain_row_zero, r_draining, r_row == '0, "row counter left zero in drain")
    `LSP_ASSERT_IMPLY(a_col_in_range, 1'b1, r_col <= w_last_col, "column beyond grid width")
    `LSP_ASSERT_IMPLY(a_row_in_range, 1'b1, r_row < w_rows_eff, "row beyond grid height")
    `LSP_ASSERT_NEXT(a_drain_end, w_take_drain && w_col_last, !r_draining && r_col == '0, "no restart after last point")

endmodule

`default_nettype wire
